// File: sv/tcw_pkg.sv
// Shared constants, codes and controller/datapath interface types for the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  localparam int ACT_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = COLOR_W + CHAR_W;

  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_BLANK    = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  typedef struct packed {
    logic latch;
    logic put_char;
    logic back_step;
    logic line_next;
    logic home;
    logic cnt_bottom;
    logic fill_write;
    logic fill_reset_color;
    logic copy_read;
    logic set_scrolled;
    logic capture_read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             is_newline;
    logic             col_last;
    logic             col_zero;
    logic             row_last;
    logic             cnt_last;
    logic             copy_last;
    logic             out_hold;
  } status_t;

endpackage
`default_nettype wire

// File: sv/tcw_datapath.sv
// Datapath of the text console writer: screen memory, cursor, sweep counter and result registers.
`default_nettype none
module tcw_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tcw_pkg::cmd_t                 cmd,
  output tcw_pkg::status_t                   status,
  input  wire logic [tcw_pkg::ACT_W-1:0]     action,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  input  wire logic                          cfg_valid,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tcw_pkg::POS_W-1:0]          cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]         cell_data,
  output logic                               scrolled
);

  logic [tcw_pkg::CELL_W-1:0]  mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0]  rd_data;
  logic [tcw_pkg::ADDR_W-1:0]  rd_addr;
  logic                        wr_en;
  logic [tcw_pkg::ADDR_W-1:0]  wr_addr;
  logic [tcw_pkg::CELL_W-1:0]  wr_data;

  logic [tcw_pkg::COLOR_W-1:0] text_color;
  logic [tcw_pkg::ROW_W-1:0]   row;
  logic [tcw_pkg::COL_W-1:0]   col;
  logic [tcw_pkg::ADDR_W-1:0]  base;
  logic [tcw_pkg::ADDR_W-1:0]  cnt;
  logic                        copy_pend;
  logic [tcw_pkg::ADDR_W-1:0]  copy_dst;

  logic [tcw_pkg::ACT_W-1:0]   item_action;
  logic [tcw_pkg::CHAR_W-1:0]  item_char;
  logic [tcw_pkg::INDEX_W-1:0] item_index;
  logic [tcw_pkg::CELL_W-1:0]  res_data;
  logic                        res_scrolled;

  logic [tcw_pkg::ADDR_W-1:0]  cursor_addr;
  logic [tcw_pkg::CELL_W-1:0]  blank_cell;
  logic                        index_ok;

  assign cursor_addr = base + tcw_pkg::ADDR_W'(col);
  assign blank_cell  = {text_color, tcw_pkg::CH_BLANK};
  assign index_ok    = int'(item_index) < tcw_pkg::CELLS;

  assign status.action     = item_action;
  assign status.is_newline = (item_char == tcw_pkg::CH_NEWLINE);
  assign status.col_last   = (col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign status.col_zero   = (col == '0);
  assign status.row_last   = (row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign status.cnt_last   = (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
  assign status.copy_last  =
    (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1));
  assign status.out_hold   = out_valid && out_stall;

  always_comb begin
    rd_addr = tcw_pkg::ADDR_W'(item_index);
    if (cmd.copy_read) begin
      rd_addr = cnt + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cursor_addr;
    wr_data = blank_cell;
    if (copy_pend) begin
      wr_en   = 1'b1;
      wr_addr = copy_dst;
      wr_data = rd_data;
    end else if (cmd.fill_write) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = cmd.fill_reset_color ? {tcw_pkg::RESET_COLOR, tcw_pkg::CH_BLANK} : blank_cell;
    end else if (cmd.put_char) begin
      wr_en   = 1'b1;
      wr_data = {text_color, item_char};
    end else if (cmd.back_step) begin
      wr_en   = 1'b1;
      wr_addr = cursor_addr - tcw_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
      row        <= '0;
      col        <= '0;
      base       <= '0;
      cnt        <= '0;
      copy_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
      copy_pend <= cmd.copy_read;
      if (cmd.copy_read) begin
        copy_dst <= cnt;
      end
      if (cmd.cnt_bottom) begin
        cnt <= tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
      end else if (cmd.fill_write || cmd.copy_read) begin
        cnt <= status.cnt_last ? '0 : cnt + tcw_pkg::ADDR_W'(1);
      end
      if (cmd.home) begin
        row  <= '0;
        col  <= '0;
        base <= '0;
      end else if (cmd.line_next) begin
        col <= '0;
        if (!status.row_last) begin
          row  <= row + tcw_pkg::ROW_W'(1);
          base <= base + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        end
      end else if (cmd.put_char) begin
        col <= status.col_last ? '0 : col + tcw_pkg::COL_W'(1);
      end else if (cmd.back_step) begin
        col <= col - tcw_pkg::COL_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_action  <= action;
      item_char    <= char_code;
      item_index   <= cell_index;
      res_data     <= '0;
      res_scrolled <= 1'b0;
    end else begin
      if (cmd.set_scrolled) begin
        res_scrolled <= 1'b1;
      end
      if (cmd.capture_read) begin
        res_data <= index_ok ? rd_data : '0;
      end
    end
    if (cmd.load_out) begin
      cursor_position <= tcw_pkg::POS_W'(cursor_addr);
      cell_data       <= res_data;
      scrolled        <= res_scrolled;
    end
  end

endmodule
`default_nettype wire

// File: sv/tcw_controller.sv
// Controller state machine of the text console writer, sequencing each request through the datapath.
`default_nettype none
module tcw_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tcw_pkg::status_t status,
  output tcw_pkg::cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LINE,
    S_COPY,
    S_FLUSH,
    S_FILL,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.fill_write       = 1'b1;
        cmd.fill_reset_color = 1'b1;
        if (status.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.action)
          tcw_pkg::ACT_PUT: begin
            if (status.is_newline) begin
              state_next = S_LINE;
            end else begin
              cmd.put_char = 1'b1;
              state_next   = status.col_last ? S_LINE : S_FINISH;
            end
          end
          tcw_pkg::ACT_BACK: begin
            cmd.back_step = !status.col_zero;
            state_next    = S_FINISH;
          end
          tcw_pkg::ACT_CLEAR: begin
            cmd.home   = 1'b1;
            state_next = S_FILL;
          end
          tcw_pkg::ACT_READ: begin
            state_next = S_READ;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_READ: begin
        cmd.capture_read = 1'b1;
        state_next       = S_FINISH;
      end
      S_LINE: begin
        cmd.line_next = 1'b1;
        if (status.row_last) begin
          cmd.set_scrolled = 1'b1;
          state_next       = S_COPY;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_COPY: begin
        cmd.copy_read = 1'b1;
        if (status.copy_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.cnt_bottom = 1'b1;
        state_next     = S_FILL;
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        if (status.cnt_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status.out_hold) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/text_console_writer.sv
// Top level of the text console writer: a controller and a datapath around one screen memory.
// A put or backspace runs the execute state, then the finish state that loads the result;
// a newline, a put in the last column or a read passes the line or read state in between.
// The controller takes requests again in the cycle the result appears. Clear and scroll
// sweep the screen memory a cell a cycle. A stalled result holds the controller in its last
// state; one request at a time. Reset blanks each cell in colour 0x07; requests wait for it.
`default_nettype none
module text_console_writer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcw_pkg::ACT_W-1:0]     action,
  input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tcw_pkg::POS_W-1:0]          cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]         cell_data,
  output logic                               scrolled,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tcw_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .action          (action),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled)
  );

endmodule
`default_nettype wire

// File: verif/text_console_writer_tb.sv
// Self-checking testbench for the text console writer against a model screen image.
`timescale 1ns / 100ps
module text_console_writer_tb;

  localparam int CYCLE_LIMIT = 12_000_000;

  typedef struct packed {
    logic [tcw_pkg::POS_W-1:0]  pos;
    logic [tcw_pkg::CELL_W-1:0] data;
    logic                       scr;
  } console_reply_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [tcw_pkg::ACT_W-1:0]     action;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::INDEX_W-1:0]   cell_index;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [tcw_pkg::POS_W-1:0]     cursor_position;
  logic [tcw_pkg::CELL_W-1:0]    cell_data;
  logic                          scrolled;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tcw_pkg::COLOR_W-1:0]   cfg_data;

  logic [tcw_pkg::CELL_W-1:0]    screen_image [tcw_pkg::CELLS];
  int unsigned                   cur_row;
  int unsigned                   cur_col;
  logic [tcw_pkg::COLOR_W-1:0]   colour_now;
  console_reply_t                expected_replies [$];

  int unsigned                   cycle_count = 0;
  int unsigned                   mismatches = 0;
  int unsigned                   requests_sent;
  int unsigned                   replies_checked = 0;
  int unsigned                   reads_sent;
  int unsigned                   clears_sent;
  int unsigned                   scrolls_seen = 0;
  int unsigned                   colour_writes;
  int unsigned                   stall_left = 0;
  bit                            steady_send;
  bit                            steady_sink;

  text_console_writer uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned random_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit step_to_next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row < tcw_pkg::ROWS) return 1'b0;
    for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
      screen_image[i] = screen_image[i + tcw_pkg::COLUMNS];
    for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
      screen_image[i] = {colour_now, tcw_pkg::CH_BLANK};
    cur_row = tcw_pkg::ROWS - 1;
    return 1'b1;
  endfunction

  task automatic predict_reply(input logic [tcw_pkg::ACT_W-1:0] act,
                               input logic [tcw_pkg::CHAR_W-1:0] ch,
                               input logic [tcw_pkg::INDEX_W-1:0] idx);
    console_reply_t r;
    int unsigned    pos;
    r = '0;
    case (act)
      tcw_pkg::ACT_PUT: begin
        if (ch == tcw_pkg::CH_NEWLINE) begin
          r.scr = step_to_next_line();
        end else begin
          screen_image[cur_row * tcw_pkg::COLUMNS + cur_col] = {colour_now, ch};
          cur_col++;
          if (cur_col >= tcw_pkg::COLUMNS) r.scr = step_to_next_line();
        end
      end
      tcw_pkg::ACT_BACK: begin
        if (cur_col > 0) begin
          cur_col--;
          screen_image[cur_row * tcw_pkg::COLUMNS + cur_col] =
            {colour_now, tcw_pkg::CH_BLANK};
        end
      end
      tcw_pkg::ACT_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELLS; i++)
          screen_image[i] = {colour_now, tcw_pkg::CH_BLANK};
        cur_row = 0;
        cur_col = 0;
        clears_sent++;
      end
      tcw_pkg::ACT_READ: begin
        if (idx < tcw_pkg::CELLS) r.data = screen_image[idx];
        reads_sent++;
      end
      default: begin
      end
    endcase
    pos = cur_row * tcw_pkg::COLUMNS + cur_col;
    r.pos = pos[tcw_pkg::POS_W-1:0];
    expected_replies.push_back(r);
  endtask

  task automatic drop_valid();
    in_valid = 1'b0;
    action = tcw_pkg::ACT_W'($urandom_range(0, 3));
    char_code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    cell_index = tcw_pkg::INDEX_W'($urandom_range(0, 2047));
  endtask

  task automatic send_request(input logic [tcw_pkg::ACT_W-1:0] act,
                              input logic [tcw_pkg::CHAR_W-1:0] ch,
                              input logic [tcw_pkg::INDEX_W-1:0] idx);
    int unsigned pause;
    pause = steady_send ? 0 : random_pause();
    if (pause != 0) begin
      drop_valid();
      repeat (pause) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    char_code = ch;
    cell_index = idx;
    do @(posedge clk); while (in_stall);
    predict_reply(act, ch, idx);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    drop_valid();
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_text_colour(input logic [tcw_pkg::COLOR_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    colour_now = value;
    colour_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = tcw_pkg::COLOR_W'($urandom_range(0, 255));
  endtask

  task automatic test_reset_contents();
    send_request(tcw_pkg::ACT_READ, 8'h00, '0);
    send_request(tcw_pkg::ACT_READ, 8'hFF, tcw_pkg::INDEX_W'(tcw_pkg::CELLS - 1));
    send_request(tcw_pkg::ACT_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::CELLS));
    send_request(tcw_pkg::ACT_READ, tcw_pkg::CH_NEWLINE, '1);
  endtask

  task automatic test_put_and_backspace();
    send_request(tcw_pkg::ACT_PUT, 8'h00, '0);
    send_request(tcw_pkg::ACT_PUT, 8'hFF, '1);
    send_request(tcw_pkg::ACT_PUT, 8'h41, '0);
    send_request(tcw_pkg::ACT_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::ACT_READ, 8'h00, 11'd1);
    send_request(tcw_pkg::ACT_READ, 8'h00, 11'd2);
    send_request(tcw_pkg::ACT_BACK, 8'hFF, '1);
    send_request(tcw_pkg::ACT_READ, 8'h00, 11'd2);
    send_request(tcw_pkg::ACT_PUT, tcw_pkg::CH_NEWLINE, '0);
    send_request(tcw_pkg::ACT_BACK, 8'h00, '0);
    send_request(tcw_pkg::ACT_PUT, 8'h42, '0);
    send_request(tcw_pkg::ACT_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::COLUMNS));
  endtask

  task automatic test_clear_screen();
    wait_idle();
    set_text_colour(8'hF0);
    send_request(tcw_pkg::ACT_CLEAR, 8'h41, '1);
    send_request(tcw_pkg::ACT_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::ACT_READ, 8'h00, tcw_pkg::INDEX_W'(tcw_pkg::CELLS - 1));
  endtask

  task automatic put_text_line();
    int unsigned r;
    int unsigned len;
    int unsigned pos;
    r = $urandom_range(0, 99);
    if (r < 60) len = $urandom_range(0, 12);
    else if (r < 90) len = $urandom_range(13, 40);
    else len = $urandom_range(70, 100);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_request(tcw_pkg::ACT_BACK, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                     tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
      end else if (r < 10) begin
        pos = cur_row * tcw_pkg::COLUMNS + cur_col;
        send_request(tcw_pkg::ACT_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                     tcw_pkg::INDEX_W'((pos == 0) ? 0 : pos - 1));
      end else begin
        send_request(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                     tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
      end
    end
    if ($urandom_range(0, 4) != 0)
      send_request(tcw_pkg::ACT_PUT, tcw_pkg::CH_NEWLINE,
                   tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic test_random_phase(input logic [tcw_pkg::COLOR_W-1:0] colour,
                                   input int unsigned count,
                                   input bit no_send_gaps, input bit no_sink_stalls);
    int unsigned start;
    int unsigned r;
    wait_idle();
    set_text_colour(colour);
    steady_send = no_send_gaps;
    steady_sink = no_sink_stalls;
    start = requests_sent;
    while (requests_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        put_text_line();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4))
          send_request(tcw_pkg::ACT_PUT, tcw_pkg::CH_NEWLINE,
                       tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
      end else if (r < 83) begin
        repeat ($urandom_range(1, 5))
          send_request(tcw_pkg::ACT_BACK, tcw_pkg::CHAR_W'($urandom_range(0, 255)), '0);
      end else if (r < 95) begin
        if ($urandom_range(0, 99) < 85)
          send_request(tcw_pkg::ACT_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                       tcw_pkg::INDEX_W'($urandom_range(0, tcw_pkg::CELLS - 1)));
        else
          send_request(tcw_pkg::ACT_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                       tcw_pkg::INDEX_W'($urandom_range(tcw_pkg::CELLS, 2047)));
      end else if (r < 96) begin
        send_request(tcw_pkg::ACT_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                     tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
      end else begin
        send_request(tcw_pkg::ACT_W'($urandom_range(0, 3)),
                     tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                     tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
      end
    end
    steady_send = 1'b0;
    steady_sink = 1'b0;
  endtask

  always @(negedge clk) begin
    if (steady_sink || rst) begin
      out_stall = 1'b0;
    end else if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall = 1'b1;
      stall_left = random_pause();
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : check_replies
    console_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: pos %0d data %h scrolled %0b",
                   cursor_position, cell_data, scrolled);
      end else begin
        want = expected_replies.pop_front();
        if (want.pos !== cursor_position || want.data !== cell_data ||
            want.scr !== scrolled) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("Mismatch on result %0d: expected pos %0d data %h scrolled %0b,",
                   replies_checked, want.pos, want.data, want.scr);
            $display(" got pos %0d data %h scrolled %0b",
                     cursor_position, cell_data, scrolled);
          end
        end
        if (want.scr) scrolls_seen++;
      end
      replies_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = tcw_pkg::ACT_PUT;
    char_code = '0;
    cell_index = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    steady_send = 1'b0;
    steady_sink = 1'b0;
    requests_sent = 0;
    reads_sent = 0;
    clears_sent = 0;
    colour_writes = 0;
    colour_now = tcw_pkg::RESET_COLOR;
    cur_row = 0;
    cur_col = 0;
    for (int i = 0; i < tcw_pkg::CELLS; i++)
      screen_image[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_BLANK};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_text_colour(8'h1F);
    test_reset_contents();
    test_put_and_backspace();
    test_clear_screen();
    test_random_phase(8'h00, 225, 1'b0, 1'b0);
    test_random_phase(8'hFF, 225, 1'b0, 1'b0);
    test_random_phase(tcw_pkg::COLOR_W'($urandom_range(0, 255)), 225, 1'b1, 1'b1);
    test_random_phase(tcw_pkg::RESET_COLOR, 225, 1'b0, 1'b0);
    test_random_phase(tcw_pkg::COLOR_W'($urandom_range(0, 255)), 225, 1'b0, 1'b1);
    test_random_phase(tcw_pkg::COLOR_W'($urandom_range(0, 255)), 225, 1'b1, 1'b0);

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Summary: %0d requests sent (%0d reads, %0d clears), %0d results checked",
             requests_sent, reads_sent, clears_sent, replies_checked);
    $display("Summary: %0d scrolls seen, %0d colour settings, %0d mismatches",
             scrolls_seen, colour_writes, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
